/* design/rgpw_pkg.sv */
// Package with the shared types and constants of the RSSI-gated pulse width capture block.
`timescale 1ns / 1ps

package rgpw_pkg;

	localparam int TIME_BITS_DEF = 20;
	localparam int WIDTH_BITS = 16;
	localparam int CFG_TIME_BITS = 20;
	localparam int COUNT_BITS = 16;
	localparam int RSSI_BITS = 9;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 20;

	localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_DBM = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TICKS = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_LIMIT = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PULSE_TICKS = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_TICKS = 3'd4;

	localparam logic signed [RSSI_BITS-1:0] GATE_DBM_RST = -9'sd70;
	localparam logic [CFG_TIME_BITS-1:0] WINDOW_TICKS_RST = 20'd400000;
	localparam logic [COUNT_BITS-1:0] PULSE_LIMIT_RST = 16'd1000;
	localparam logic [WIDTH_BITS-1:0] MIN_PULSE_TICKS_RST = 16'd80;
	localparam logic [CFG_TIME_BITS-1:0] SETTLE_TICKS_RST = 20'd50000;

	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

	localparam logic KIND_PULSE = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_CAPTURE = 2'd1,
		MODE_SETTLE = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [RSSI_BITS-1:0] gate_dbm;
		logic [CFG_TIME_BITS-1:0] window_ticks;
		logic [COUNT_BITS-1:0] pulse_limit;
		logic [WIDTH_BITS-1:0] min_pulse_ticks;
		logic [CFG_TIME_BITS-1:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic [WIDTH_BITS-1:0] pulse_width;
		logic [COUNT_BITS-1:0] frame_length;
		logic signed [RSSI_BITS-1:0] trigger_rssi;
		logic final_level;
	} res_t;

endpackage

/* design/rgpw_cfg.sv */
// Configuration register file of the RSSI-gated pulse width capture block.
`timescale 1ns / 1ps

module rgpw_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rgpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [rgpw_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output rgpw_pkg::cfg_t cfg
);
	import rgpw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_dbm <= GATE_DBM_RST;
			cfg_q.window_ticks <= WINDOW_TICKS_RST;
			cfg_q.pulse_limit <= PULSE_LIMIT_RST;
			cfg_q.min_pulse_ticks <= MIN_PULSE_TICKS_RST;
			cfg_q.settle_ticks <= SETTLE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GATE_DBM: cfg_q.gate_dbm <= $signed(cfg_data[RSSI_BITS-1:0]);
				REG_WINDOW_TICKS: cfg_q.window_ticks <= cfg_data[CFG_TIME_BITS-1:0];
				REG_PULSE_LIMIT: cfg_q.pulse_limit <= cfg_data[COUNT_BITS-1:0];
				REG_MIN_PULSE_TICKS: cfg_q.min_pulse_ticks <= cfg_data[WIDTH_BITS-1:0];
				REG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data[CFG_TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/rgpw_core.sv */
// Frame state machine, tick counters and result formation of the pulse width capture.
`timescale 1ns / 1ps

module rgpw_core #(
	parameter int TIME_BITS = rgpw_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input rgpw_pkg::cfg_t cfg,
	input logic step,
	input logic line_level,
	input logic signed [rgpw_pkg::RSSI_BITS-1:0] rssi_dbm,
	output rgpw_pkg::res_t res
);
	import rgpw_pkg::*;

	localparam int CW = (TIME_BITS > CFG_TIME_BITS) ? TIME_BITS : CFG_TIME_BITS;
	localparam int DW = (TIME_BITS > WIDTH_BITS) ? TIME_BITS : WIDTH_BITS;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	mode_t mode_q, mode_d;
	logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
	logic [TIME_BITS-1:0] since_q, since_d;
	logic prev_level_q, prev_level_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic signed [RSSI_BITS-1:0] latched_rssi_q, latched_rssi_d;
	logic [CFG_TIME_BITS-1:0] settle_q, settle_d;

	logic frame_end;
	logic start;
	logic edge_seen;
	logic keep_pulse;
	logic [TIME_BITS-1:0] elapsed_inc;
	logic [TIME_BITS-1:0] since_inc;
	logic [DW-1:0] delta_ext;
	logic [CFG_TIME_BITS-1:0] settle_dec;

	assign frame_end = (CW'(elapsed_q) >= CW'(cfg.window_ticks)) || (count_q >= cfg.pulse_limit);
	assign start = $signed(rssi_dbm) > $signed(cfg.gate_dbm);
	assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign since_inc = (since_q == TIME_MAX) ? since_q : since_q + 1'b1;
	assign edge_seen = line_level != prev_level_q;
	assign delta_ext = DW'(since_inc);
	assign keep_pulse = edge_seen && (delta_ext > DW'(cfg.min_pulse_ticks));
	assign settle_dec = (settle_q != '0) ? settle_q - 1'b1 : settle_q;

	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_CAPTURE: begin
				if (frame_end) begin
					mode_d = (cfg.settle_ticks == '0) ? MODE_IDLE : MODE_SETTLE;
				end
			end
			MODE_SETTLE: begin
				if (settle_dec == '0) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = start ? MODE_CAPTURE : MODE_IDLE;
			end
		endcase
	end

	always_comb begin
		elapsed_d = elapsed_q;
		since_d = since_q;
		prev_level_d = prev_level_q;
		count_d = count_q;
		latched_rssi_d = latched_rssi_q;
		settle_d = settle_q;
		res.valid = 1'b0;
		res.kind = KIND_PULSE;
		res.pulse_width = '0;
		res.frame_length = '0;
		res.trigger_rssi = latched_rssi_q;
		res.final_level = prev_level_q;
		case (mode_q)
			MODE_CAPTURE: begin
				if (frame_end) begin
					res.valid = 1'b1;
					res.kind = KIND_SUMMARY;
					res.frame_length = count_q;
					settle_d = cfg.settle_ticks;
				end else begin
					elapsed_d = elapsed_inc;
					since_d = since_inc;
					if (edge_seen) begin
						since_d = '0;
						prev_level_d = line_level;
					end
					if (keep_pulse) begin
						count_d = count_q + 1'b1;
						res.valid = 1'b1;
						res.pulse_width = (delta_ext > DW'(WIDTH_MAX)) ? WIDTH_MAX
							: delta_ext[WIDTH_BITS-1:0];
						res.final_level = line_level;
					end
				end
			end
			MODE_SETTLE: begin
				settle_d = settle_dec;
			end
			default: begin
				if (start) begin
					latched_rssi_d = rssi_dbm;
					prev_level_d = line_level;
					elapsed_d = '0;
					since_d = '0;
					count_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			elapsed_q <= '0;
			since_q <= '0;
			prev_level_q <= 1'b0;
			count_q <= '0;
			latched_rssi_q <= '0;
			settle_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			elapsed_q <= elapsed_d;
			since_q <= since_d;
			prev_level_q <= prev_level_d;
			count_q <= count_d;
			latched_rssi_q <= latched_rssi_d;
			settle_q <= settle_d;
		end
	end

endmodule

/* design/rssi_gated_pulse_width_capture.sv */
// Top level of the RSSI-gated pulse width capture block.
//
//   channel  direction  words                     handshake
//   s_axis   in         one tick: level, RSSI     tvalid / tready
//   m_axis   out        pulse width or summary    tvalid / tready
//   cfg      in         register write            cfg_we, no stall
//
// A tick word is taken into an input register and handled once the output register is empty
// or being read; the frame state and counters then update and any result is loaded into the
// output register, from which it is presented on m_axis. One word per cycle is sustained while
// m_axis is not stalled. The input stage advances whenever the output register is empty or being
// read, so a stalled output holds back the core and the input side. Reset clears the core state
// and the valid flags and loads the register defaults; the block accepts words as soon as reset ends.
`timescale 1ns / 1ps

module rssi_gated_pulse_width_capture #(
	parameter int TIME_BITS = rgpw_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // line_level, rssi_dbm, zero fill
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // pulse_width, frame_length, trigger_rssi, final_level, zero fill
	output logic m_axis_tuser, // kind
	input logic cfg_we,
	input logic [rgpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [rgpw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import rgpw_pkg::*;

	cfg_t cfg;
	res_t res;

	logic valid_s1;
	logic level_s1;
	logic signed [RSSI_BITS-1:0] rssi_s1;
	logic advance;

	logic out_valid_q;
	logic kind_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [COUNT_BITS-1:0] length_q;
	logic signed [RSSI_BITS-1:0] rssi_q;
	logic level_q;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	rgpw_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	rgpw_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(advance),
		.line_level(level_s1),
		.rssi_dbm(rssi_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			level_s1 <= s_axis_tdata[0];
			rssi_s1 <= $signed(s_axis_tdata[RSSI_BITS:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q <= res.kind;
			width_q <= res.pulse_width;
			length_q <= res.frame_length;
			rssi_q <= res.trigger_rssi;
			level_q <= res.final_level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = kind_q;
	assign m_axis_tdata = {6'd0, level_q, rssi_q, length_q, width_q};

endmodule
